@@ rtl/steering_angle_from_velocity_defines.svh @@
// Assertion macros shared by the checker.
`ifndef STEERING_ANGLE_FROM_VELOCITY_DEFINES_SVH
`define STEERING_ANGLE_FROM_VELOCITY_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define SAV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sav: implication check failed");

// Implication with a fixed delay in cycles.
`define SAV_ASSERT_DLY(label, ante, dly, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error("sav: delayed check failed");

`endif

@@ rtl/sav_pkg.sv @@
package sav_pkg;

    localparam int DW        = 43;  // x/y datapath, 24 fraction bits
    localparam int ZW        = 30;  // angle accumulator, 2^-20 degree
    localparam int TABLE_LEN = 24;
    localparam int HW        = ZW + 1 - 13;  // rounded heading before saturation

    localparam logic signed [ZW-1:0] DEG90         = 30'sd94371840;
    localparam logic signed [ZW-1:0] ROUND_HALF    = 30'sd4096;
    localparam logic signed [HW-1:0] HALF_TURN_OUT = 18'sd23040;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
    } t_vel_in;

    typedef struct packed {
        logic signed [15:0] heading;
        logic               is_still;
    } t_head_out;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 still;
        logic                 zero;
    } t_cordic;

    // round(atan(2^-i) degrees * 2^20)
    function automatic logic signed [ZW-1:0] atan_of(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = 30'sd47185920;
            5'd1:    v = 30'sd27855475;
            5'd2:    v = 30'sd14718068;
            5'd3:    v = 30'sd7471121;
            5'd4:    v = 30'sd3750058;
            5'd5:    v = 30'sd1876857;
            5'd6:    v = 30'sd938658;
            5'd7:    v = 30'sd469357;
            5'd8:    v = 30'sd234682;
            5'd9:    v = 30'sd117342;
            5'd10:   v = 30'sd58671;
            5'd11:   v = 30'sd29335;
            5'd12:   v = 30'sd14668;
            5'd13:   v = 30'sd7334;
            5'd14:   v = 30'sd3667;
            5'd15:   v = 30'sd1833;
            5'd16:   v = 30'sd917;
            5'd17:   v = 30'sd458;
            5'd18:   v = 30'sd229;
            5'd19:   v = 30'sd115;
            5'd20:   v = 30'sd57;
            5'd21:   v = 30'sd29;
            5'd22:   v = 30'sd14;
            5'd23:   v = 30'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/sav_prerot.sv @@
module sav_prerot (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  sav_pkg::t_vel_in   i_vel,
    input  logic [14:0]        i_deadband,
    output logic               o_vld,
    output sav_pkg::t_cordic   o_d
);

    logic                          r_vld;
    sav_pkg::t_cordic              r_d;
    sav_pkg::t_cordic              n_d;
    logic signed [16:0]            sx, sy;
    logic        [16:0]            ax, ay;
    logic signed [sav_pkg::DW-1:0] px, py;

    always_comb begin
        sx = {i_vel.vel_x[15], i_vel.vel_x};
        sy = {i_vel.vel_y[15], i_vel.vel_y};
        ax = sx[16] ? 17'(-sx) : 17'(sx);
        ay = sy[16] ? 17'(-sy) : 17'(sy);
        // scale by 2^24
        px = {{(sav_pkg::DW-40){i_vel.vel_x[15]}}, i_vel.vel_x, 24'd0};
        py = {{(sav_pkg::DW-40){i_vel.vel_y[15]}}, i_vel.vel_y, 24'd0};

        n_d.still = (ax < {2'b00, i_deadband}) && (ay < {2'b00, i_deadband});
        n_d.zero  = (i_vel.vel_x == '0) && (i_vel.vel_y == '0);

        // turn left half plane into right half plane
        if (px < 0) begin
            if (py >= 0) begin
                n_d.x = py;
                n_d.y = -px;
                n_d.z = sav_pkg::DEG90;
            end else begin
                n_d.x = -py;
                n_d.y = px;
                n_d.z = -sav_pkg::DEG90;
            end
        end else begin
            n_d.x = px;
            n_d.y = py;
            n_d.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_d <= n_d;
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

@@ rtl/sav_stage.sv @@
module sav_stage #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  sav_pkg::t_cordic i_d,
    output logic             o_vld,
    output sav_pkg::t_cordic o_d
);

    logic                          r_vld;
    sav_pkg::t_cordic              r_d;
    sav_pkg::t_cordic              n_d;
    logic signed [sav_pkg::DW-1:0] dx, dy;
    logic signed [sav_pkg::ZW-1:0] da;
    logic                          y_pos;

    always_comb begin
        dx    = i_d.y >>> IDX;
        dy    = i_d.x >>> IDX;
        da    = sav_pkg::atan_of(5'(IDX));
        y_pos = !i_d.y[sav_pkg::DW-1] && (i_d.y != '0);
        n_d   = i_d;
        if (y_pos) begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + da;
        end else begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_d <= n_d;
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

@@ rtl/sav_round.sv @@
module sav_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  sav_pkg::t_cordic    i_d,
    output logic                o_vld,
    output sav_pkg::t_head_out  o_res
);

    logic                          r_vld;
    sav_pkg::t_head_out            r_res;
    sav_pkg::t_head_out            n_res;
    logic signed [sav_pkg::ZW:0]   zr;
    logic signed [sav_pkg::HW-1:0] h;

    always_comb begin
        // round half up to 1/128 degree
        zr = {i_d.z[sav_pkg::ZW-1], i_d.z} + {sav_pkg::ROUND_HALF[sav_pkg::ZW-1],
                                              sav_pkg::ROUND_HALF};
        h  = sav_pkg::HW'(zr >>> 13);
        // fold minus 180 onto plus 180, clip overshoot
        if (h <= -sav_pkg::HALF_TURN_OUT || h > sav_pkg::HALF_TURN_OUT) begin
            h = sav_pkg::HALF_TURN_OUT;
        end
        if (i_d.still) begin
            n_res.heading  = '0;
            n_res.is_still = 1'b1;
        end else if (i_d.zero) begin
            n_res.heading  = '0;
            n_res.is_still = 1'b0;
        end else begin
            n_res.heading  = h[15:0];
            n_res.is_still = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_res <= n_res;
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule

@@ rtl/steering_angle_from_velocity.sv @@
// channel   direction  handshake                       payload
// item in   input      start, busy (busy stays low)     i_vel   (vel_x, vel_y)
// result    output     o_strobe, one cycle              o_head  (heading, is_still)
// config    input      i_cfg_valid, o_cfg_ready         i_cfg_data (deadband)
//
// One item enters per cycle; its result strobes after passing through
// one pre-rotation stage, one stage per micro-rotation and a rounding stage.
// Synchronous reset clears the valid bits and sets deadband to 1; no clearing pass.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module steering_angle_from_velocity #(
    parameter int ITERATIONS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sav_pkg::t_vel_in    i_vel,
    output logic                o_strobe,
    output sav_pkg::t_head_out  o_head,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [14:0]         i_cfg_data
);

    localparam int NITER = (ITERATIONS < sav_pkg::TABLE_LEN) ? ITERATIONS
                                                             : sav_pkg::TABLE_LEN;

    logic [14:0]      r_deadband;
    logic             stg_vld [NITER+1];
    sav_pkg::t_cordic stg_d   [NITER+1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= 15'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_deadband <= i_cfg_data;
        end
    end

    sav_prerot u_prerot (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (start && !busy),
        .i_vel      (i_vel),
        .i_deadband (r_deadband),
        .o_vld      (stg_vld[0]),
        .o_d        (stg_d[0])
    );

    for (genvar g = 0; g < NITER; g++) begin : g_stage
        sav_stage #(
            .IDX (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (stg_vld[g]),
            .i_d     (stg_d[g]),
            .o_vld   (stg_vld[g+1]),
            .o_d     (stg_d[g+1])
        );
    end

    sav_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (stg_vld[NITER]),
        .i_d     (stg_d[NITER]),
        .o_vld   (o_strobe),
        .o_res   (o_head)
    );

endmodule

@@ rtl/sav_checker.sv @@
`include "steering_angle_from_velocity_defines.svh"

module sav_checker #(
    parameter int ITERATIONS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input sav_pkg::t_head_out o_head
);

    localparam int LAT = ((ITERATIONS < sav_pkg::TABLE_LEN) ? ITERATIONS
                                                            : sav_pkg::TABLE_LEN) + 2;

    `SAV_ASSERT_IMP(a_still_zero, o_strobe && o_head.is_still, o_head.heading == 16'sd0)
    `SAV_ASSERT_IMP(a_range, o_strobe, ($signed(o_head.heading) >= -16'sd23039) && ($signed(o_head.heading) <= 16'sd23040))
    `SAV_ASSERT_DLY(a_latency, start && !busy, LAT, o_strobe)
    `SAV_ASSERT_IMP(a_no_orphan, o_strobe, $past(start && !busy, LAT))

endmodule

bind steering_angle_from_velocity sav_checker #(.ITERATIONS(ITERATIONS)) u_sav_checker (.*);

@@ verif/heading_checker.sv @@
module heading_checker
    import sav_pkg::*;
#(
    parameter int ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_vel_in     i_vel,
    input  logic        i_strobe,
    input  t_head_out   i_head,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [14:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);

    localparam int     ROT_STAGES = (ITERATIONS < 24) ? ITERATIONS : 24;
    localparam longint QUARTER_Q20 = 64'sd94371840;
    localparam longint HALF_TURN   = 64'sd23040;

    // atan(2^-i) in degrees, 20 fraction bits
    localparam longint ATAN_Q20 [0:23] = '{
        64'sd47185920, 64'sd27855475, 64'sd14718068, 64'sd7471121,
        64'sd3750058,  64'sd1876857,  64'sd938658,   64'sd469357,
        64'sd234682,   64'sd117342,   64'sd58671,    64'sd29335,
        64'sd14668,    64'sd7334,     64'sd3667,     64'sd1833,
        64'sd917,      64'sd458,      64'sd229,      64'sd115,
        64'sd57,       64'sd29,       64'sd14,       64'sd7
    };

    logic [14:0] deadband;
    t_head_out   heading_q [$];
    int          fails = 0;

    assign o_pending    = heading_q.size();
    assign o_fail_count = fails;

    function automatic t_head_out predict_heading(input t_vel_in v, input logic [14:0] db);
        longint    sx, sy, ax, ay, x, y, z, t, dx, dy, h;
        t_head_out r;
        sx = longint'($signed(v.vel_x));
        sy = longint'($signed(v.vel_y));
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        r.heading  = '0;
        r.is_still = 1'b0;
        if (ax < longint'(db) && ay < longint'(db)) begin
            r.is_still = 1'b1;
            return r;
        end
        if (sx == 0 && sy == 0) begin
            return r;
        end
        x = sx * 64'sd16777216;
        y = sy * 64'sd16777216;
        z = 0;
        // fold the left half plane into the right one; y == 0 goes +90
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = QUARTER_Q20;
            end else begin
                x = -y;
                y = t;
                z = -QUARTER_Q20;
            end
        end
        for (int i = 0; i < ROT_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_Q20[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_Q20[i];
            end
        end
        h = (z + 64'sd4096) >>> 13;
        // fold -180 onto +180, clamp overshoot
        if (h <= -HALF_TURN || h > HALF_TURN) h = HALF_TURN;
        r.heading = h[15:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        t_head_out want;
        if (!i_rst_n) begin
            deadband = 15'd1;
            heading_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) deadband = i_cfg_data;
            if (i_strobe) begin
                if (heading_q.size() == 0) begin
                    $error("unexpected result: heading %0d, is_still %0b",
                           $signed(i_head.heading), i_head.is_still);
                    fails++;
                end else begin
                    want = heading_q.pop_front();
                    if (i_head.heading !== want.heading) begin
                        $error("heading mismatch: expected %0d, actual %0d",
                               $signed(want.heading), $signed(i_head.heading));
                        fails++;
                    end
                    if (i_head.is_still !== want.is_still) begin
                        $error("is_still mismatch: expected %0b, actual %0b",
                               want.is_still, i_head.is_still);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) heading_q.push_back(predict_heading(i_vel, deadband));
        end
    end

endmodule

@@ verif/tb.sv @@
module tb;
    import sav_pkg::*;

    localparam int ITERATIONS   = 16;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_ITEMS  = 170;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_vel_in     vel = '0;
    logic        o_strobe;
    t_head_out   o_head;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [14:0] cfg_data = '0;
    int          pending;
    int          fail_count;
    int          cur_deadband = 1;
    int          idle_cycles = 0;

    steering_angle_from_velocity #(
        .ITERATIONS (ITERATIONS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_vel       (vel),
        .o_strobe    (o_strobe),
        .o_head      (o_head),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    heading_checker #(
        .ITERATIONS (ITERATIONS)
    ) heading_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_vel        (vel),
        .i_strobe     (o_strobe),
        .i_head       (o_head),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_vel(input int x, input int y);
        @(negedge i_clk);
        start     = 1'b1;
        vel.vel_x = 16'(x);
        vel.vel_y = 16'(y);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause(input int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // hold off until every item in flight has produced its result
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_deadband(input int value);
        drain();
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data  = 15'(value);
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        cur_deadband = value;
    endtask

    function automatic int rand_component();
        int m;
        case ($urandom_range(0, 9))
            4, 5: begin
                // straddle the deadband edge
                m = cur_deadband + $urandom_range(0, 4) - 2;
                if (m < 0) m = 0;
            end
            6: begin
                case ($urandom_range(0, 5))
                    0: m = -32768;
                    1: m = 32767;
                    2: m = -32767;
                    3: m = 0;
                    4: m = 1;
                    default: m = -1;
                endcase
                return m;
            end
            7: m = $urandom_range(0, 8);
            default: return int'($signed(16'($urandom)));
        endcase
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    task automatic send_random();
        int x, y;
        x = rand_component();
        y = rand_component();
        case ($urandom_range(0, 7))
            0: if ($urandom_range(0, 1)) x = 0; else y = 0;
            1: y = $urandom_range(0, 1) ? x : -x;
            default: ;
        endcase
        send_vel(x, y);
    endtask

    task automatic run_random(input int count);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 30);
            if (burst > left) burst = left;
            repeat (burst) send_random();
            left -= burst;
            case ($urandom_range(0, 9))
                0, 1, 2: ;
                3:       drain();
                default: pause($urandom_range(1, 12));
            endcase
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset deadband of one: only the zero vector is still
        send_vel(0, 0);
        send_vel(1, 0);
        send_vel(0, 1);
        send_vel(-1, 0);
        send_vel(32767, 32767);
        send_vel(-32768, -32768);
        send_vel(-32768, 0);
        send_vel(-32768, -1);
        send_vel(-32768, 1);
        send_vel(0, -32768);
        send_vel(32767, -32768);
        send_vel(-32768, 32767);
        send_vel(32767, 0);
        send_vel(-1, -1);

        // zero deadband: the zero vector is not still
        write_deadband(0);
        send_vel(0, 0);
        send_vel(1, 1);

        write_deadband(100);
        send_vel(99, -99);
        send_vel(-99, 100);
        send_vel(100, 0);

        write_deadband(32767);
        send_vel(32766, -32766);
        send_vel(-32767, 0);
        send_vel(-32768, -32768);
        send_vel(32767, 32767);

        write_deadband($urandom_range(2, 200));
        run_random(PHASE_ITEMS);
        write_deadband(0);
        run_random(PHASE_ITEMS);
        write_deadband(32767);
        run_random(PHASE_ITEMS);
        write_deadband($urandom_range(0, 32767));
        run_random(PHASE_ITEMS);
        write_deadband(1);
        run_random(PHASE_ITEMS);

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
